/* design/qapm_pkg.sv */
// Shared types, constants and the control-store program for the attitude PD mixer.
`default_nettype none

package qapm_pkg;

  localparam int QW          = 16;
  localparam int MOTOR_CNT   = 4;
  localparam int MOTOR_W     = $clog2(MOTOR_CNT);
  localparam int PC_W        = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int ADJ_W       = 17;
  localparam int MIX_W       = 18;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_DERIV_GAIN    = 3'd1,
    REG_FORGET_FACTOR = 3'd2,
    REG_MAX_ADJUST    = 3'd3,
    REG_YAW_ERR_LIMIT = 3'd4,
    REG_SETTLE_TICKS  = 3'd5,
    REG_BASE_PERIOD   = 3'd6
  } reg_idx_e;

  localparam logic [23:0] PROP_GAIN_RST     = 24'd16384;
  localparam logic [23:0] DERIV_GAIN_RST    = 24'd655360;
  localparam logic [15:0] FORGET_FACTOR_RST = 16'd6554;
  localparam logic [15:0] MAX_ADJUST_RST    = 16'd64000;
  localparam logic [14:0] YAW_ERR_LIMIT_RST = 15'd13107;
  localparam logic [15:0] SETTLE_TICKS_RST  = 16'd300;
  localparam logic [7:0]  BASE_PERIOD_RST   = 8'd10;
  localparam logic signed [QW-1:0] TARGET_RE_RST = 16'sd32767;

  typedef struct packed {
    logic [23:0] prop_gain;
    logic [23:0] deriv_gain;
    logic [15:0] forget_factor;
    logic [15:0] max_adjust;
    logic [14:0] yaw_err_limit;
    logic [15:0] settle_ticks;
    logic [7:0]  base_period;
  } cfg_t;

  typedef enum logic [2:0] {
    ACC_HOLD, ACC_LOAD, ACC_LOADN, ACC_ADD, ACC_SUB
  } acc_op_e;

  typedef enum logic [3:0] {
    A_W, A_Z, A_TRE, A_TIM, A_PG, A_DG, A_FF, A_TL, A_TH
  } asel_e;

  typedef enum logic [2:0] {
    B_X, B_Y, B_M, B_DV, B_BASE, B_F
  } bsel_e;

  typedef enum logic [1:0] {
    SH_0, SH_15, SH_24
  } shift_e;

  typedef enum logic [3:0] {
    SP_NONE, SP_TICK, SP_ROLL, SP_PITCH, SP_YAW, SP_MIX, SP_RND, SP_DVP, SP_TERM, SP_ADJ
  } spec_e;

  typedef enum logic [1:0] {
    JMP_NEXT, JMP_LOOP, JMP_END
  } jmp_e;

  typedef struct packed {
    acc_op_e         acc;
    asel_e           asel;
    bsel_e           bsel;
    shift_e          shift;
    spec_e           spec;
    jmp_e            jmp;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic               load;
    logic               en;
    logic [MOTOR_W-1:0] motor;
    uword_t             uw;
  } ctrl_t;

  localparam logic [PC_W-1:0] PC_MOTOR_LOOP = 4'd7;

  // per motor step: MIX, RND, m*Kp, -dv*Kd, base*ff, +tl*f, +th*f, ADJ
  function automatic uword_t ucode(logic [PC_W-1:0] pc);
    uword_t w;
    w.acc    = ACC_HOLD;
    w.asel   = A_W;
    w.bsel   = B_X;
    w.shift  = SH_0;
    w.spec   = SP_NONE;
    w.jmp    = JMP_NEXT;
    w.target = PC_MOTOR_LOOP;
    case (pc)
      4'd0: begin
        w.spec = SP_TICK;  w.acc = ACC_LOADN; w.asel = A_W;   w.bsel = B_X;
      end
      4'd1: begin
        w.acc = ACC_SUB;   w.asel = A_Z;     w.bsel = B_Y;
      end
      4'd2: begin
        w.spec = SP_ROLL;  w.acc = ACC_LOAD;  w.asel = A_W;   w.bsel = B_Y;
      end
      4'd3: begin
        w.acc = ACC_SUB;   w.asel = A_Z;     w.bsel = B_X;
      end
      4'd4: begin
        w.spec = SP_PITCH; w.acc = ACC_LOAD;  w.asel = A_TRE; w.bsel = B_Y;
      end
      4'd5: begin
        w.acc = ACC_SUB;   w.asel = A_TIM;   w.bsel = B_X;
      end
      4'd6: w.spec = SP_YAW;
      4'd7: w.spec = SP_MIX;
      4'd8: w.spec = SP_RND;
      4'd9: begin
        w.spec = SP_DVP;   w.acc = ACC_LOAD;  w.asel = A_PG;  w.bsel = B_M;
      end
      4'd10: begin
        w.acc = ACC_SUB;   w.asel = A_DG;    w.bsel = B_DV;
      end
      4'd11: begin
        w.spec = SP_TERM;  w.acc = ACC_LOAD;  w.asel = A_FF;  w.bsel = B_BASE;
        w.shift = SH_15;
      end
      4'd12: begin
        w.acc = ACC_ADD;   w.asel = A_TL;    w.bsel = B_F;
      end
      4'd13: begin
        w.acc = ACC_ADD;   w.asel = A_TH;    w.bsel = B_F;   w.shift = SH_24;
      end
      4'd14: begin
        w.spec = SP_ADJ;   w.jmp = JMP_LOOP;
      end
      default: w.jmp = JMP_END;
    endcase
    return w;
  endfunction

  // {negate roll, negate pitch, negate yaw} for the X-frame mix
  function automatic logic [2:0] motor_sign(logic [MOTOR_W-1:0] motor);
    logic [2:0] s;
    case (motor)
      2'd0:    s = 3'b000;
      2'd1:    s = 3'b110;
      2'd2:    s = 3'b101;
      default: s = 3'b011;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

/* design/quad_attitude_pd_mixer_top.sv */
// Top level of the quadcopter attitude PD mixer: config registers, input requantize, output word.
// One word goes in per control tick and one result word comes out. A word is worked on by a
// 16-step control-store program driving a single 25x25 multiplier with a 64-bit accumulator:
// 7 steps for the tilt and yaw terms, then 8 steps per motor for the four motors, then a
// handoff step. The input stalls while a word is worked on, so no new input word is taken
// before the last one is through its handoff step. The result word sits in an output
// register, so the next input word is accepted while it waits; the handoff step holds only
// if the previous result has still not been taken. A register write takes effect at once,
// so write the registers only while no word is in flight.
`default_nettype none

module quad_attitude_pd_mixer_top import qapm_pkg::*; #(
  parameter int QUAT_WIDTH = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire        [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire        [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire  signed [QUAT_WIDTH-1:0] quat_w_i,
  input  wire  signed [QUAT_WIDTH-1:0] quat_x_i,
  input  wire  signed [QUAT_WIDTH-1:0] quat_y_i,
  input  wire  signed [QUAT_WIDTH-1:0] quat_z_i,
  input  wire                          capture_yaw_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic signed [ADJ_W-1:0]      adj_right_head_o,
  output logic signed [ADJ_W-1:0]      adj_left_tail_o,
  output logic signed [ADJ_W-1:0]      adj_left_head_o,
  output logic signed [ADJ_W-1:0]      adj_right_tail_o,
  output logic                         settled_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain     <= PROP_GAIN_RST;
      cfg_q.deriv_gain    <= DERIV_GAIN_RST;
      cfg_q.forget_factor <= FORGET_FACTOR_RST;
      cfg_q.max_adjust    <= MAX_ADJUST_RST;
      cfg_q.yaw_err_limit <= YAW_ERR_LIMIT_RST;
      cfg_q.settle_ticks  <= SETTLE_TICKS_RST;
      cfg_q.base_period   <= BASE_PERIOD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PROP_GAIN:     cfg_q.prop_gain     <= cfg_wdata_i;
        REG_DERIV_GAIN:    cfg_q.deriv_gain    <= cfg_wdata_i;
        REG_FORGET_FACTOR: cfg_q.forget_factor <= cfg_wdata_i[15:0];
        REG_MAX_ADJUST:    cfg_q.max_adjust    <= cfg_wdata_i[15:0];
        REG_YAW_ERR_LIMIT: cfg_q.yaw_err_limit <= cfg_wdata_i[14:0];
        REG_SETTLE_TICKS:  cfg_q.settle_ticks  <= cfg_wdata_i[15:0];
        REG_BASE_PERIOD:   cfg_q.base_period   <= cfg_wdata_i[7:0];
        default:           cfg_q               <= cfg_q;
      endcase
    end
  end

  // requantize to Q1.15, floor
  logic [3:0][QUAT_WIDTH-1:0] q_raw;
  logic [3:0][QW-1:0]         q16;

  assign q_raw = {quat_z_i, quat_y_i, quat_x_i, quat_w_i};

  for (genvar g = 0; g < 4; g++) begin : g_requant
    if (QUAT_WIDTH >= QW) begin : g_trunc
      assign q16[g] = q_raw[g][QUAT_WIDTH-1 -: QW];
    end else begin : g_pad
      assign q16[g] = {q_raw[g], {(QW - QUAT_WIDTH){1'b0}}};
    end
  end

  ctrl_t ctrl;
  logic  done, out_free;
  logic  out_valid_q;
  logic  [MOTOR_CNT-1:0][ADJ_W-1:0] res;
  logic  settled;

  assign out_free = !out_valid_q || !out_stall_i;

  qapm_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .in_stall_o (in_stall_o),
    .done_o     (done),
    .ctrl_o     (ctrl)
  );

  qapm_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .cfg_i         (cfg_q),
    .quat_w_i      ($signed(q16[0])),
    .quat_x_i      ($signed(q16[1])),
    .quat_y_i      ($signed(q16[2])),
    .quat_z_i      ($signed(q16[3])),
    .capture_yaw_i (capture_yaw_i),
    .res_o         (res),
    .settled_o     (settled)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      adj_right_head_o <= $signed(res[0]);
      adj_left_tail_o  <= $signed(res[1]);
      adj_left_head_o  <= $signed(res[2]);
      adj_right_tail_o <= $signed(res[3]);
      settled_o        <= settled;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* design/qapm_seq.sv */
// Control-store sequencer: step counter, motor loop counter and handshake control.
`default_nettype none

module qapm_seq import qapm_pkg::*; (
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   in_valid_i,
  input  wire   out_free_i,
  output logic  in_stall_o,
  output logic  done_o,
  output ctrl_t ctrl_o
);

  logic               busy_q;
  logic [PC_W-1:0]    pc_q;
  logic [MOTOR_W-1:0] motor_q;
  uword_t             uw;

  assign uw = ucode(pc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      pc_q    <= '0;
      motor_q <= '0;
    end else if (!busy_q) begin
      if (in_valid_i) begin
        busy_q  <= 1'b1;
        pc_q    <= '0;
        motor_q <= '0;
      end
    end else begin
      case (uw.jmp)
        JMP_NEXT: pc_q <= pc_q + 1'b1;
        JMP_LOOP: begin
          if (motor_q != MOTOR_W'(MOTOR_CNT - 1)) begin
            motor_q <= motor_q + 1'b1;
            pc_q    <= uw.target;
          end else begin
            pc_q <= pc_q + 1'b1;
          end
        end
        JMP_END: begin
          if (out_free_i) busy_q <= 1'b0;
        end
        default: pc_q <= pc_q;
      endcase
    end
  end

  assign in_stall_o   = busy_q;
  assign done_o       = busy_q && (uw.jmp == JMP_END) && out_free_i;
  assign ctrl_o.load  = !busy_q && in_valid_i;
  assign ctrl_o.en    = busy_q;
  assign ctrl_o.motor = motor_q;
  assign ctrl_o.uw    = uw;

endmodule

`default_nettype wire

/* design/qapm_dp.sv */
// Datapath: shared multiplier with accumulator, tick state and per-motor PD state.
`default_nettype none

module qapm_dp import qapm_pkg::*; (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  ctrl_t                              ctrl_i,
  input  cfg_t                               cfg_i,
  input  wire  signed [QW-1:0]               quat_w_i,
  input  wire  signed [QW-1:0]               quat_x_i,
  input  wire  signed [QW-1:0]               quat_y_i,
  input  wire  signed [QW-1:0]               quat_z_i,
  input  wire                                capture_yaw_i,
  output logic        [MOTOR_CNT-1:0][ADJ_W-1:0] res_o,
  output logic                               settled_o
);

  logic signed [QW-1:0]    qw_q, qx_q, qy_q, qz_q;
  logic                    cap_q;
  logic [15:0]             tick_q;
  logic [7:0]              phase_q;
  logic                    settled_q, refresh_q;
  logic signed [QW-1:0]    tre_q, tim_q;
  logic signed [63:0]      acc_q, acc_d;
  logic signed [32:0]      roll_q, pitch_q;
  logic signed [31:0]      yaw_q;
  logic signed [33:0]      mix_q;
  logic signed [MIX_W-1:0] m_q;
  logic signed [MIX_W:0]   dv_q;
  logic signed [43:0]      term_q;
  logic signed [MIX_W-1:0] prev_q [MOTOR_CNT];
  logic signed [ADJ_W-1:0] base_q [MOTOR_CNT];
  logic        [ADJ_W-1:0] res_q  [MOTOR_CNT];

  logic [MOTOR_W-1:0] mi;
  assign mi = ctrl_i.motor;

  // shared multiplier
  logic [16:0]        f_w;
  logic signed [24:0] mul_a, mul_b;
  logic signed [49:0] prod;
  logic signed [63:0] p64, addend;

  assign f_w = 17'h10000 - {1'b0, cfg_i.forget_factor};

  always_comb begin
    case (ctrl_i.uw.asel)
      A_W:     mul_a = 25'(qw_q);
      A_Z:     mul_a = 25'(qz_q);
      A_TRE:   mul_a = 25'(tre_q);
      A_TIM:   mul_a = 25'(tim_q);
      A_PG:    mul_a = $signed({1'b0, cfg_i.prop_gain});
      A_DG:    mul_a = $signed({1'b0, cfg_i.deriv_gain});
      A_FF:    mul_a = $signed({9'b0, cfg_i.forget_factor});
      A_TL:    mul_a = $signed({1'b0, term_q[23:0]});
      A_TH:    mul_a = 25'($signed(term_q[43:24]));
      default: mul_a = '0;
    endcase
    case (ctrl_i.uw.bsel)
      B_X:     mul_b = 25'(qx_q);
      B_Y:     mul_b = 25'(qy_q);
      B_M:     mul_b = 25'(m_q);
      B_DV:    mul_b = 25'(dv_q);
      B_BASE:  mul_b = 25'(base_q[mi]);
      B_F:     mul_b = $signed({8'b0, f_w});
      default: mul_b = '0;
    endcase
  end

  assign prod = mul_a * mul_b;
  assign p64  = 64'(prod);

  always_comb begin
    case (ctrl_i.uw.shift)
      SH_15:   addend = p64 <<< 15;
      SH_24:   addend = p64 <<< 24;
      default: addend = p64;
    endcase
    case (ctrl_i.uw.acc)
      ACC_LOAD:  acc_d = addend;
      ACC_LOADN: acc_d = -addend;
      ACC_ADD:   acc_d = acc_q + addend;
      ACC_SUB:   acc_d = acc_q - addend;
      default:   acc_d = acc_q;
    endcase
  end

  // tick bookkeeping
  logic        stepped, settled_n, capture_n, refresh_n;
  logic [15:0] tick_n;
  logic [7:0]  phase_n, period;

  assign stepped   = tick_q != 16'hFFFF;
  assign tick_n    = stepped ? tick_q + 16'd1 : tick_q;
  assign settled_n = tick_n >= cfg_i.settle_ticks;
  assign capture_n = cap_q || (stepped && (tick_n == cfg_i.settle_ticks));
  assign period    = (cfg_i.base_period == 8'd0) ? 8'd1 : cfg_i.base_period;
  assign phase_n   = phase_q + 8'd1;
  assign refresh_n = phase_n >= period;

  // yaw error clamp
  logic signed [34:0] yaw4;
  logic signed [35:0] ylim;
  logic signed [31:0] yaw_n;

  assign yaw4 = {acc_q[32:0], 2'b00};
  assign ylim = $signed({6'b0, cfg_i.yaw_err_limit, 15'b0});

  always_comb begin
    if (!settled_q)               yaw_n = '0;
    else if (36'(yaw4) > ylim)    yaw_n = 32'(ylim);
    else if (36'(yaw4) < -ylim)   yaw_n = 32'(-ylim);
    else                          yaw_n = 32'(yaw4);
  end

  // motor mix
  logic [2:0]         sg;
  logic signed [33:0] r34, p34, y34, mix_n;

  assign sg    = motor_sign(mi);
  assign r34   = sg[2] ? -34'(roll_q)  : 34'(roll_q);
  assign p34   = sg[1] ? -34'(pitch_q) : 34'(pitch_q);
  assign y34   = sg[0] ? -34'(yaw_q)   : 34'(yaw_q);
  assign mix_n = r34 + p34 + y34;

  // round to Q.15 and saturate
  logic signed [34:0]      mix_r;
  logic signed [19:0]      mix_s;
  logic signed [MIX_W-1:0] m_n;

  assign mix_r = 35'(mix_q) + 35'sd16384;
  assign mix_s = mix_r[34:15];

  always_comb begin
    if (mix_s > 20'sd131071)       m_n = 18'sd131071;
    else if (mix_s < -20'sd131072) m_n = -18'sd131072;
    else                           m_n = mix_s[MIX_W-1:0];
  end

  // final adjustment
  logic signed [63:0]      acc_r;
  logic signed [32:0]      adj_s, amax;
  logic signed [ADJ_W-1:0] adj_n;

  assign acc_r = acc_q + 64'sd1073741824;
  assign adj_s = acc_r[63:31];
  assign amax  = $signed({17'b0, cfg_i.max_adjust});

  always_comb begin
    if (adj_s > amax)       adj_n = $signed({1'b0, cfg_i.max_adjust});
    else if (adj_s < -amax) adj_n = -$signed({1'b0, cfg_i.max_adjust});
    else                    adj_n = adj_s[ADJ_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q    <= '0;
      phase_q   <= '0;
      settled_q <= 1'b0;
      refresh_q <= 1'b0;
      tre_q     <= TARGET_RE_RST;
      tim_q     <= '0;
      for (int i = 0; i < MOTOR_CNT; i++) begin
        prev_q[i] <= '0;
        base_q[i] <= '0;
      end
    end else if (ctrl_i.en) begin
      case (ctrl_i.uw.spec)
        SP_TICK: begin
          tick_q    <= tick_n;
          settled_q <= settled_n;
          refresh_q <= refresh_n;
          phase_q   <= refresh_n ? 8'd0 : phase_n;
          if (capture_n) begin
            tre_q <= qx_q;
            tim_q <= qy_q;
          end
        end
        SP_DVP: prev_q[mi] <= m_q;
        SP_ADJ: begin
          if (refresh_q) base_q[mi] <= adj_n;
        end
        default: tick_q <= tick_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      qw_q  <= quat_w_i;
      qx_q  <= quat_x_i;
      qy_q  <= quat_y_i;
      qz_q  <= quat_z_i;
      cap_q <= capture_yaw_i;
    end
    if (ctrl_i.en) begin
      acc_q <= acc_d;
      case (ctrl_i.uw.spec)
        SP_ROLL:  roll_q  <= acc_q[32:0];
        SP_PITCH: pitch_q <= acc_q[32:0];
        SP_YAW:   yaw_q   <= yaw_n;
        SP_MIX:   mix_q   <= mix_n;
        SP_RND:   m_q     <= m_n;
        SP_DVP:   dv_q    <= (MIX_W + 1)'(prev_q[mi]) - (MIX_W + 1)'(m_q);
        SP_TERM:  term_q  <= acc_q[43:0];
        SP_ADJ:   res_q[mi] <= settled_q ? adj_n : '0;
        default:  mix_q   <= mix_q;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < MOTOR_CNT; i++) res_o[i] = res_q[i];
  end

  assign settled_o = settled_q;

endmodule

`default_nettype wire
